### rtl/posting_list_and_or_merge_top_macros.svh
// Assertion macros shared by the posting-list merge RTL.
`ifndef POSTING_LIST_AND_OR_MERGE_TOP_MACROS_SVH
`define POSTING_LIST_AND_OR_MERGE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define PLM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never hold outside reset.
`define PLM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PLM_ASSERT(label, clk, rst_n, prop, msg)
`define PLM_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

### rtl/plm_pkg.sv
// Types and constants of the posting-list AND / OR merge block.
`default_nettype none

package plm_pkg;

  localparam int unsigned LIST_DEPTH = 32;
  localparam int unsigned IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned ID_W       = 32;

  localparam logic LIST_A = 1'b0;
  localparam logic LIST_B = 1'b1;

  typedef struct packed {
    logic            list_select;
    logic            carries_id;
    logic [ID_W-1:0] doc_id;
    logic            end_of_list;
    logic            mode_and;
  } in_item_t;

  typedef struct packed {
    logic            result_valid;
    logic [ID_W-1:0] result_id;
    logic            last_result;
    logic            overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OUT_RD,
    S_OUT_WAIT,
    S_IN_RD,
    S_IN_CMP,
    S_EMIT,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    PH_AND,
    PH_OR_A,
    PH_OR_B
  } phase_e;

endpackage

`default_nettype wire

### rtl/plm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module plm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/posting_list_and_or_merge_top.sv
// Top level of the posting-list AND / OR merge block.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+-----------------------
//   in      | input     | in_valid_i / in_ready_o  | in_item_i  (in_item_t)
//   out     | output    | out_valid_o / out_ready_i| out_item_o (out_item_t)
//
// An item that does not close list B is taken while the block is idle; an
// item that carries an id is stored into list RAM A or B while that list
// has room. The item that closes list B starts the merge, which runs on one
// shared 32-bit equality comparator. AND takes each id of A as a candidate
// and scans B for it; OR first emits every id of A, then takes each id of B
// and scans A for it. A scan stops at the first match or at the list end.
// Reset clears the counts, the overflow flag and the control state; list
// contents are not cleared, since only entries below the counts are read.
// Input is refused for the whole merge; a full output register stalls the
// sequencer without losing work.
`default_nettype none

`include "posting_list_and_or_merge_top_macros.svh"

module posting_list_and_or_merge_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire plm_pkg::in_item_t   in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output plm_pkg::out_item_t       out_item_o
);

  import plm_pkg::*;

  // Sequencer state and the pass that is running.
  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  // Fill counts of both lists and the sticky drop flag of this run.
  logic [CNT_W-1:0] count_a_q, count_a_d;
  logic [CNT_W-1:0] count_b_q, count_b_d;
  logic             dropped_q, dropped_d;

  // Outer index walks the candidate list, inner index the list searched.
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [CNT_W-1:0] i_next, j_next;

  // Current candidate, and one kept result held back so that the final one
  // can be marked as last.
  logic [ID_W-1:0] cand_q, cand_d;
  logic [ID_W-1:0] pend_q, pend_d;
  logic            pend_v_q, pend_v_d;

  // Output register.
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;
  logic      push;

  // List RAM ports.
  logic             a_we, b_we;
  logic [IDX_W-1:0] a_raddr, b_raddr, outer_addr, inner_addr;
  logic [ID_W-1:0]  a_rdata, b_rdata, outer_rdata, inner_rdata;

  // Shared decision terms of the sequencer.
  logic             accept, closes_b, push_ok, hit, is_and;
  logic [CNT_W-1:0] n_outer, n_inner;
  logic             outer_done, inner_empty_end, inner_scan_end, keep;

  assign accept   = in_valid_i && in_ready_o;
  assign closes_b = (in_item_i.list_select == LIST_B) && in_item_i.end_of_list;
  assign push_ok  = !out_valid_q || out_ready_i;
  assign is_and   = (phase_q == PH_AND);

  assign i_next = i_q + CNT_W'(1);
  assign j_next = j_q + CNT_W'(1);

  // In the second OR pass list B supplies the candidates and A is searched.
  assign n_outer     = (phase_q == PH_OR_B) ? count_b_q : count_a_q;
  assign n_inner     = (phase_q == PH_OR_B) ? count_a_q : count_b_q;
  assign outer_rdata = (phase_q == PH_OR_B) ? b_rdata : a_rdata;
  assign inner_rdata = (phase_q == PH_OR_B) ? a_rdata : b_rdata;

  // While comparing, the next inner entry is already being read.
  assign outer_addr = i_q[IDX_W-1:0];
  assign inner_addr = (state_q == S_IN_CMP) ? j_next[IDX_W-1:0] : j_q[IDX_W-1:0];
  assign a_raddr    = (phase_q == PH_OR_B) ? inner_addr : outer_addr;
  assign b_raddr    = (phase_q == PH_OR_B) ? outer_addr : inner_addr;

  // The one comparator of the block.
  assign hit = (inner_rdata == cand_q);

  assign outer_done      = (i_q == n_outer);
  assign inner_empty_end = (j_q == n_inner);
  assign inner_scan_end  = hit || (j_next == n_inner);
  // AND keeps a candidate found in B; OR keeps a B id not found in A.
  assign keep = (state_q == S_IN_CMP) ? (is_and ? hit : !hit) : !is_and;

  assign a_we = accept && in_item_i.carries_id && (in_item_i.list_select == LIST_A)
                && (count_a_q != CNT_W'(LIST_DEPTH));
  assign b_we = accept && in_item_i.carries_id && (in_item_i.list_select == LIST_B)
                && (count_b_q != CNT_W'(LIST_DEPTH));

  plm_ram #(
    .WIDTH (ID_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (count_a_q[IDX_W-1:0]),
    .wdata_i (in_item_i.doc_id),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  plm_ram #(
    .WIDTH (ID_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (count_b_q[IDX_W-1:0]),
    .wdata_i (in_item_i.doc_id),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && closes_b) begin
          state_d = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        if (!outer_done) begin
          state_d = S_OUT_WAIT;
        end else if (phase_q != PH_OR_A) begin
          state_d = S_FINISH;
        end
      end
      S_OUT_WAIT: begin
        state_d = (phase_q == PH_OR_A) ? S_EMIT : S_IN_RD;
      end
      S_IN_RD: begin
        if (inner_empty_end) begin
          state_d = keep ? S_EMIT : S_OUT_RD;
        end else begin
          state_d = S_IN_CMP;
        end
      end
      S_IN_CMP: begin
        if (inner_scan_end) begin
          state_d = keep ? S_EMIT : S_OUT_RD;
        end
      end
      S_EMIT: begin
        if (!pend_v_q || push_ok) begin
          state_d = S_OUT_RD;
        end
      end
      S_FINISH: begin
        if (push_ok) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and output updates.
  always_comb begin
    phase_d   = phase_q;
    count_a_d = count_a_q;
    count_b_d = count_b_q;
    dropped_d = dropped_q;
    i_d       = i_q;
    j_d       = j_q;
    cand_d    = cand_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    out_d     = out_q;
    push      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (a_we) begin
            count_a_d = count_a_q + CNT_W'(1);
          end
          if (b_we) begin
            count_b_d = count_b_q + CNT_W'(1);
          end
          if (in_item_i.carries_id && !a_we && !b_we) begin
            dropped_d = 1'b1;
          end
          if (closes_b) begin
            phase_d  = in_item_i.mode_and ? PH_AND : PH_OR_A;
            i_d      = '0;
            pend_v_d = 1'b0;
          end
        end
      end
      S_OUT_RD: begin
        if (outer_done && (phase_q == PH_OR_A)) begin
          phase_d = PH_OR_B;
          i_d     = '0;
        end
      end
      S_OUT_WAIT: begin
        cand_d = outer_rdata;
        j_d    = '0;
      end
      S_IN_RD: begin
        if (inner_empty_end && !keep) begin
          i_d = i_next;
        end
      end
      S_IN_CMP: begin
        if (!inner_scan_end) begin
          j_d = j_next;
        end else if (!keep) begin
          i_d = i_next;
        end
      end
      S_EMIT: begin
        if (!pend_v_q || push_ok) begin
          if (pend_v_q) begin
            push  = 1'b1;
            out_d = '{result_valid: 1'b1, result_id: pend_q,
                      last_result: 1'b0, overflow: dropped_q};
          end
          pend_d   = cand_q;
          pend_v_d = 1'b1;
          i_d      = i_next;
        end
      end
      S_FINISH: begin
        if (push_ok) begin
          push  = 1'b1;
          out_d = '{result_valid: pend_v_q,
                    result_id: pend_v_q ? pend_q : '0,
                    last_result: 1'b1, overflow: dropped_q};
          count_a_d = '0;
          count_b_d = '0;
          dropped_d = 1'b0;
          pend_v_d  = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_AND;
      count_a_q   <= '0;
      count_b_q   <= '0;
      dropped_q   <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      count_a_q   <= count_a_d;
      count_b_q   <= count_b_d;
      dropped_q   <= dropped_d;
      i_q         <= i_d;
      j_q         <= j_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // Fill counts never pass the list depth.
  `PLM_ASSERT_NEVER(a_count_range, clk_i, rst_ni,
    (count_a_q > CNT_W'(LIST_DEPTH)) || (count_b_q > CNT_W'(LIST_DEPTH)),
    "list count beyond depth")

  // Closing an answer clears the run state for the next one.
  `PLM_ASSERT(a_finish_clears, clk_i, rst_ni,
    (state_q == S_FINISH) && push_ok |=> (count_a_q == '0) && (count_b_q == '0)
      && !dropped_q && !pend_v_q && in_ready_o,
    "run state not cleared after final result")

  // An empty-answer marker is always the last result of its answer.
  `PLM_ASSERT(a_empty_is_last, clk_i, rst_ni,
    out_valid_o && !out_item_o.result_valid |-> out_item_o.last_result,
    "empty-answer marker without last flag")

  // A result is loaded only when the output register is free or draining.
  `PLM_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
    push && out_valid_q && !out_ready_i,
    "pending result overwritten")

endmodule

`default_nettype wire
